/* sv/aes128_pkg.sv */
// Package for the AES-128 block decryption pipeline: S-box tables, GF(2^8)
// helpers and the inverse round functions. No dependencies.
`default_nettype none
package aes128_pkg;

   localparam int RoundCount = 10;

   typedef logic [127:0] block_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [0:255];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      sbox = t[x];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      logic [7:0] t [0:255];
      t = '{
         8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
         8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
         8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
         8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
         8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
         8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
         8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
         8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
         8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
         8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
         8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
         8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
         8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
         8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
         8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
         8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      inv_sbox = t[x];
   endfunction

   // Byte i of the block sits in bits 127-8i down to 120-8i.
   function automatic logic [7:0] byte_at(input block_type b, input int i);
      byte_at = b[127-8*i -: 8];
   endfunction

   // Inverse shift rows followed by the inverse S-box on every byte.
   function automatic block_type inv_shift_sub(input block_type s);
      block_type t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(c*4+r) -: 8] = inv_sbox(byte_at(s, ((c - r + 4) % 4) * 4 + r));
         end
      end
      inv_shift_sub = t;
   endfunction

   function automatic block_type inv_mix(input block_type s);
      block_type t;
      logic [7:0] a [0:3];
      logic [7:0] x2 [0:3];
      logic [7:0] x4 [0:3];
      logic [7:0] x8 [0:3];
      logic [7:0] m9 [0:3];
      logic [7:0] mb [0:3];
      logic [7:0] md [0:3];
      logic [7:0] me [0:3];
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            a[r]  = byte_at(s, c*4+r);
            x2[r] = xtime(a[r]);
            x4[r] = xtime(x2[r]);
            x8[r] = xtime(x4[r]);
            m9[r] = x8[r] ^ a[r];
            mb[r] = x8[r] ^ x2[r] ^ a[r];
            md[r] = x8[r] ^ x4[r] ^ a[r];
            me[r] = x8[r] ^ x4[r] ^ x2[r];
         end
         t[127-8*(c*4)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
         t[127-8*(c*4+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
         t[127-8*(c*4+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
         t[127-8*(c*4+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      end
      inv_mix = t;
   endfunction

   // One step of the forward key schedule.
   function automatic block_type next_key(input block_type k, input logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, tw;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      tw = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ tw;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      next_key = {w0, w1, w2, w3};
   endfunction

endpackage
`default_nettype wire

/* sv/aes128_block_decrypt.sv */
// Top level of the pipelined AES-128 decryptor: round key registers and
// eleven register stages, the last driving the output. Depends on aes128_pkg.
//
//   channel   direction  handshake          payload
//   req_      in         tvalid / tready    tdata = {cipher_low, cipher_high}
//   rsp_      out        tvalid / tready    tdata = {plain_low, plain_high}
//   csr_      in         valid / ready      index (1 bit), data (64 bits)
//
// A word passes through eleven register stages (the first adds round key
// 10, the last adds round key 0), and one word enters every cycle while
// the output is taken and the key schedule is not busy.
// The pipeline advances as a whole when the last stage is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
// The round keys are expanded from the key registers whenever a key word
// is written: the key schedule walks one round per cycle, and the block
// takes no words until the walk after the last key write is done. Reset
// clears the key and starts the same expansion from the all-zero key.
`default_nettype none
module aes128_block_decrypt
   import aes128_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // [63:0] cipher_high, [127:64] cipher_low
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // [63:0] plain_high, [127:64] plain_low
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_index,
   input  wire logic [63:0]  csr_data
);

   localparam int StageCount = RoundCount + 1;

   block_type        key_ff;
   block_type        key_in;
   block_type        rkey_ff [0:RoundCount];
   logic [7:0]       rcon_ff;
   logic [3:0]       kcnt_ff;
   logic             kbusy_ff;

   block_type        state_ff [0:StageCount-1];
   logic [StageCount-1:0] valid_ff;
   logic             advance;
   // The cipher block with byte 0 in the top bits.
   block_type        req_block;

   assign csr_ready = 1'b1;

   always_comb begin
      key_in = key_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == 1'b0) key_in[127:64] = csr_data;
         else                   key_in[63:0]   = csr_data;
      end
   end

   // Key schedule: rkey_ff[i] holds round key i once the walk is done.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         kbusy_ff <= 1'b1;
         kcnt_ff  <= 4'd0;
         rcon_ff  <= 8'h01;
         rkey_ff[0] <= '0;
      end else if (csr_valid && csr_ready) begin
         key_ff   <= key_in;
         kbusy_ff <= 1'b1;
         kcnt_ff  <= 4'd0;
         rcon_ff  <= 8'h01;
         rkey_ff[0] <= key_in;
      end else if (kbusy_ff) begin
         rkey_ff[kcnt_ff + 4'd1] <= next_key(rkey_ff[kcnt_ff], rcon_ff);
         rcon_ff <= xtime(rcon_ff);
         kcnt_ff <= kcnt_ff + 4'd1;
         if (kcnt_ff == 4'(RoundCount - 1)) kbusy_ff <= 1'b0;
      end
   end

   assign advance    = !valid_ff[StageCount-1] || rsp_tready;
   assign req_tready = advance && !kbusy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[StageCount-2:0], req_tvalid && req_tready};
      end
   end

   // The high half travels in the low bits of the stream word.
   assign req_block = {req_tdata[63:0], req_tdata[127:64]};

   // Stage 0: add key 10, inverse shift and substitute. Stages 1 to 9: add
   // key, inverse mix, inverse shift and substitute. Stage 10: add key 0.
   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff[0] <= inv_shift_sub(req_block ^ rkey_ff[RoundCount]);
         for (int i = 1; i < RoundCount; i++) begin
            state_ff[i] <= inv_shift_sub(inv_mix(state_ff[i-1] ^ rkey_ff[RoundCount-i]));
         end
         state_ff[StageCount-1] <= state_ff[StageCount-2] ^ rkey_ff[0];
      end
   end

   assign rsp_tvalid = valid_ff[StageCount-1];
   assign rsp_tdata  = {state_ff[StageCount-1][63:0], state_ff[StageCount-1][127:64]};

endmodule
`default_nettype wire

/* test/aes128_block_decrypt_checker.sv */
// Checker for the AES-128 decryptor: watches the key, ciphertext and plaintext
// channels, predicts each plaintext and compares it. Depends on aes128_pkg.
`default_nettype none
module aes128_block_decrypt_checker
   import aes128_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [127:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [127:0] rsp_tdata,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic         csr_index,
   input  wire logic [63:0]  csr_data,
   output int                fail_count,
   output int                pending_count
);

   localparam logic KeyHighIndex = 1'b0;

   typedef logic [7:0] octet_type;

   logic [63:0] key_hi, key_lo;
   // Expected plaintexts with byte 0 in the top bits.
   logic [127:0] plain_queue[$];

   octet_type fwd_tab[256];
   octet_type inv_tab[256];

   function automatic octet_type gf_double(octet_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic octet_type gf_mul(octet_type a, octet_type b);
      octet_type acc;
      acc = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (b[0]) acc ^= a;
         a = gf_double(a);
         b = b >> 1;
      end
      return acc;
   endfunction

   // The S-boxes are derived here from field inverses and the affine map.
   initial begin
      octet_type inv, s;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256 && x != 0; y++) begin
            if (gf_mul(octet_type'(x), octet_type'(y)) == 8'h01) begin
               inv = octet_type'(y);
               break;
            end
         end
         s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         fwd_tab[x] = s;
      end
      for (int x = 0; x < 256; x++) inv_tab[fwd_tab[x]] = octet_type'(x);
   end

   function automatic logic [127:0] decrypt_block(logic [127:0] cipher);
      octet_type rk[176];
      octet_type st[16];
      octet_type tmp[16];
      octet_type t[4];
      octet_type f, rcon, a0, a1, a2, a3;
      logic [127:0] plain;
      logic [127:0] key;
      key = {key_hi, key_lo};
      rcon = 8'h01;
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[127-8*i -: 8];
         st[i] = cipher[127-8*i -: 8];
      end
      for (int i = 4; i < 44; i++) begin
         for (int j = 0; j < 4; j++) t[j] = rk[(i-1)*4+j];
         if (i % 4 == 0) begin
            f = t[0];
            t[0] = fwd_tab[t[1]] ^ rcon;
            t[1] = fwd_tab[t[2]];
            t[2] = fwd_tab[t[3]];
            t[3] = fwd_tab[f];
            rcon = gf_double(rcon);
         end
         for (int j = 0; j < 4; j++) rk[i*4+j] = rk[(i-4)*4+j] ^ t[j];
      end
      for (int round = 10; round >= 0; round--) begin
         for (int i = 0; i < 16; i++) st[i] ^= rk[16*round+i];
         if (round > 0 && round < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[c*4]; a1 = st[c*4+1]; a2 = st[c*4+2]; a3 = st[c*4+3];
               st[c*4]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
                           ^ gf_mul(a3, 8'd9);
               st[c*4+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
                           ^ gf_mul(a3, 8'd13);
               st[c*4+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
                           ^ gf_mul(a3, 8'd11);
               st[c*4+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
                           ^ gf_mul(a3, 8'd14);
            end
         end
         if (round > 0) begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  tmp[c*4+r] = inv_tab[st[((c - r + 4) % 4)*4+r]];
            st = tmp;
         end
      end
      for (int i = 0; i < 16; i++) plain[127-8*i -: 8] = st[i];
      return plain;
   endfunction

   assign pending_count = plain_queue.size();

   // On the stream the high half sits in bits 63:0 and the low half above it.
   always @(posedge clock) begin
      logic [127:0] want;
      int errs;
      errs = 0;
      if (reset) begin
         key_hi <= '0;
         key_lo <= '0;
         fail_count <= 0;
         plain_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == KeyHighIndex) key_hi <= csr_data;
            else key_lo <= csr_data;
         end
         if (req_tvalid && req_tready)
            plain_queue.push_back(decrypt_block({req_tdata[63:0], req_tdata[127:64]}));
         if (rsp_tvalid && rsp_tready) begin
            if (plain_queue.size() == 0) begin
               $display("%0t: unexpected plaintext %h", $time, rsp_tdata);
               errs++;
            end else begin
               want = plain_queue.pop_front();
               if (want[127:64] !== rsp_tdata[63:0]) begin
                  $display("%0t: plain_high expected %h actual %h", $time, want[127:64],
                           rsp_tdata[63:0]);
                  errs++;
               end
               if (want[63:0] !== rsp_tdata[127:64]) begin
                  $display("%0t: plain_low expected %h actual %h", $time, want[63:0],
                           rsp_tdata[127:64]);
                  errs++;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end

endmodule
`default_nettype wire

/* test/aes128_block_decrypt_tb.sv */
// Testbench top for the AES-128 decryptor: drives keys and ciphertext words
// with random idling and gives the verdict. Depends on aes128_pkg and the checker.
`default_nettype none
module aes128_block_decrypt_tb;
   import aes128_pkg::*;

   localparam logic KeyHigh = 1'b0;
   localparam logic KeyLow  = 1'b1;
   // Covers the eleven pipeline stages and the key expansion, with margin.
   localparam int SettleCycles = 40;
   localparam int WatchdogLimit = 2000;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [127:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [127:0] rsp_tdata;
   logic csr_valid, csr_ready, csr_index;
   logic [63:0] csr_data;
   int fail_count, pending_count;
   int idle_cycles;
   // Set once when the receiver is to hold off for a long stretch.
   logic hold_off;
   // Set in the final part of the run, where neither side idles.
   logic steady;

   aes128_block_decrypt uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   aes128_block_decrypt_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] random_half();
      return {$urandom, $urandom};
   endfunction

   // Writes both key registers back to back and waits for each to be taken.
   task automatic write_key(input logic [63:0] high, input logic [63:0] low);
      csr_valid <= 1'b1;
      csr_index <= KeyHigh;
      csr_data  <= high;
      do @(posedge clock); while (!csr_ready);
      csr_index <= KeyLow;
      csr_data  <= low;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Offers one ciphertext word, sometimes after a burst of idle cycles, and
   // returns once it has been accepted. Valid stays high between back-to-back words.
   task automatic send_block(input logic [127:0] cipher);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cipher;
      do @(posedge clock); while (!req_tready);
   endtask

   // Lowers valid and waits until every expected plaintext has arrived and the
   // key schedule can take a new key safely.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Receiver: random bursts of stall, one long hold-off when asked, none at the end.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (60) @(posedge clock);
            hold_done = 1'b1;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   // Watchdog: counts cycles in which no word of any channel is accepted.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("aes128_block_decrypt_tb NOT OK");
            $finish;
         end
      end
   end

   // Words are built as {cipher_low, cipher_high}, the high half in the low bits.
   initial begin
      logic [63:0] key_set[4][2];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = KeyHigh;
      csr_data = '0;
      hold_off = 1'b0;
      steady = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (SettleCycles) @(posedge clock);

      // Directed words under the all-zero reset key: field extremes, half-ones,
      // end-bit and alternating-bit patterns.
      send_block('0);
      send_block('1);
      send_block({64'hffff_ffff_ffff_ffff, 64'h0});
      send_block({64'h0, 64'hffff_ffff_ffff_ffff});
      send_block(128'h8000_0000_0000_0000_0000_0000_0000_0001);
      send_block(128'h5555_5555_5555_5555_aaaa_aaaa_aaaa_aaaa);
      drain();

      // Key settings: all ones, the FIPS-197 example key, the end bits, then a random key.
      key_set[0] = '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff};
      key_set[1] = '{64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f};
      key_set[2] = '{64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001};
      key_set[3] = '{random_half(), random_half()};
      for (int k = 0; k < 4; k++) begin
         write_key(key_set[k][0], key_set[k][1]);
         repeat (SettleCycles) @(posedge clock);
         if (k == 1) send_block({64'hd8cd_b780_70b4_c55a, 64'h69c4_e0d8_6a7b_0430});
         send_block('0);
         send_block('1);
         for (int i = 0; i < 150; i++) begin
            // The receiver holds off while words keep coming, filling the pipeline.
            if (k == 2 && i == 20) hold_off <= 1'b1;
            // One pause until the pipeline has emptied completely.
            if (k == 2 && i == 100) begin
               req_tvalid <= 1'b0;
               do @(posedge clock); while (pending_count != 0);
            end
            send_block({random_half(), random_half()});
         end
         drain();
      end

      // Last part: a random key, no idling on either side.
      write_key(random_half(), random_half());
      repeat (SettleCycles) @(posedge clock);
      steady <= 1'b1;
      for (int i = 0; i < 150; i++) send_block({random_half(), random_half()});
      drain();

      if (fail_count == 0) begin
         $display("aes128_block_decrypt_tb OK");
      end else begin
         $display("aes128_block_decrypt_tb NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
